>>> rtl/hamming_encode_correct_defines.svh
// Assertion macros shared by the Hamming encoder/corrector checker.
`ifndef HAMMING_ENCODE_CORRECT_DEFINES_SVH
`define HAMMING_ENCODE_CORRECT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define HEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hec_pkg.sv
// Types, constants and helper functions of the Hamming encoder/corrector.
package hec_pkg;

  localparam int MAX_MSG_BITS = 57;
  localparam int MSG_W        = 57;
  localparam int WORD_W       = 63;
  localparam int SYN_W        = 6;
  localparam int PCNT_W       = 3;
  localparam int IN_DATA_W    = 120;
  localparam int OUT_DATA_W   = 80;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_CHECK  = 1'b1
  } op_t;

  // One result; code_word sits in the lowest bits, so the packed struct
  // matches the output tdata layout directly.
  typedef struct packed {
    logic [PCNT_W-1:0] parity_count;
    logic              bad_position;
    logic              error_found;
    logic [SYN_W-1:0]  syndrome;
    logic [WORD_W-1:0] code_word;
  } result_t;

  localparam int RES_W = $bits(result_t);

  // Out-of-range lengths: 0 acts as 1, anything above the maximum saturates.
  function automatic logic [5:0] clamp_len(input logic [5:0] m);
    logic [5:0] v;
    begin
      v = m;
      if (m == 6'd0) v = 6'd1;
      else if (m > 6'(MAX_MSG_BITS)) v = 6'(MAX_MSG_BITS);
      return v;
    end
  endfunction

  // Smallest r with 2^r >= m + r + 1, as length thresholds.
  function automatic logic [PCNT_W-1:0] parity_count_for(input logic [5:0] m);
    logic [PCNT_W-1:0] r;
    begin
      if (m < 6'd2)       r = 3'd2;
      else if (m < 6'd5)  r = 3'd3;
      else if (m < 6'd12) r = 3'd4;
      else if (m < 6'd27) r = 3'd5;
      else                r = 3'd6;
      return r;
    end
  endfunction

  // Scatter message bits over the non-power-of-two positions, lowest first.
  function automatic logic [WORD_W-1:0] place_msg(input logic [MSG_W-1:0] msg,
                                                  input logic [5:0] m);
    logic [WORD_W-1:0] w;
    int j;
    begin
      w = '0;
      j = 0;
      for (int pos = 1; pos <= WORD_W; pos++) begin
        if ((pos & (pos - 1)) != 0) begin
          if (j < int'(m)) w[pos-1] = msg[j];
          j++;
        end
      end
      return w;
    end
  endfunction

  // XOR of the positions of all set bits: one XOR tree per syndrome bit.
  function automatic logic [SYN_W-1:0] pos_xor(input logic [WORD_W-1:0] w);
    logic [SYN_W-1:0] s;
    begin
      s = '0;
      for (int p = 0; p < SYN_W; p++) begin
        for (int pos = 1; pos <= WORD_W; pos++) begin
          if (((pos >> p) & 1) != 0) s[p] = s[p] ^ w[pos-1];
        end
      end
      return s;
    end
  endfunction

endpackage

>>> rtl/hec_core.sv
// Combinational encode / syndrome-and-correct datapath for one word.
module hec_core (
  input  logic                            operation,
  input  logic [hec_pkg::MSG_W-1:0]       message,
  input  logic [hec_pkg::WORD_W-1:0]      received,
  input  logic [5:0]                      msg_bits,
  output hec_pkg::result_t                res
);
  import hec_pkg::*;

  logic [5:0]        m;
  logic [PCNT_W-1:0] r;
  logic [5:0]        n;
  logic [63:0]       mask_wide;
  logic [WORD_W-1:0] word_mask;
  logic [WORD_W-1:0] data_w;
  logic [SYN_W-1:0]  enc_par;
  logic [WORD_W-1:0] enc_w;
  logic [WORD_W-1:0] rcv_w;
  logic [SYN_W-1:0]  syn;
  logic              err;
  logic              bad;
  logic [WORD_W-1:0] cor_w;

  // Active length, parity count and codeword mask
  assign m         = clamp_len(msg_bits);
  assign r         = parity_count_for(m);
  assign n         = m + 6'(r);
  assign mask_wide = (64'd1 << n) - 64'd1;
  assign word_mask = mask_wide[WORD_W-1:0];

  // Encode: data bits, then parity bits at the power-of-two positions
  assign data_w  = place_msg(message, m);
  assign enc_par = pos_xor(data_w);

  always_comb begin
    enc_w = data_w;
    for (int p = 0; p < SYN_W; p++) begin
      if (p < int'(r)) enc_w[(1 << p) - 1] = enc_par[p];
    end
  end

  // Check: syndrome over the masked word, flip the named bit if in range
  assign rcv_w = received & word_mask;
  assign syn   = pos_xor(rcv_w);
  assign err   = (syn != '0);
  assign bad   = err && (syn > n);

  always_comb begin
    cor_w = rcv_w;
    if (err && !bad) cor_w = rcv_w ^ (WORD_W'(1) << (syn - 6'd1));
  end

  // Result select
  always_comb begin
    res.parity_count = r;
    case (op_t'(operation))
      OP_ENCODE: begin
        res.code_word    = enc_w & word_mask;
        res.syndrome     = '0;
        res.error_found  = 1'b0;
        res.bad_position = 1'b0;
      end
      OP_CHECK: begin
        res.code_word    = cor_w;
        res.syndrome     = syn;
        res.error_found  = err;
        res.bad_position = bad;
      end
      default: begin
        res.code_word    = '0;
        res.syndrome     = '0;
        res.error_found  = 1'b0;
        res.bad_position = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/hamming_encode_correct.sv
// Hamming single-error-correcting encoder and checker, stream interface.
// Each request either encodes a message of msg_bits bits (1..57, 0 acts as
// 1, larger values saturate) into an even-parity Hamming codeword, or checks
// a received codeword, reports its syndrome and flips the bit it names; a
// syndrome beyond the codeword length raises bad_position and leaves the
// word as received. Requests pass an input register, combinational parity
// XOR trees, and a result register: one request per cycle is accepted while
// the receiver keeps up. A result is presented on m_axis once it has moved
// from the input register into the result register. When the receiver holds
// off, the two registers fill and s_axis_tready drops until the waiting
// result is taken. msg_bits must only be written while no request is in
// flight.
module hamming_encode_correct (
  input  logic                               clk,
  input  logic                               rst,
  // configuration: msg_bits
  input  logic                               cfg_wr_en,
  input  logic [5:0]                         cfg_wr_data,
  // request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [hec_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // message[56:0], received[119:57]
  input  logic                               s_axis_tuser,  // operation
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // code_word[62:0], syndrome[68:63], error_found[69], bad_position[70],
  // parity_count[73:71], zero fill[79:74]
  output logic [hec_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import hec_pkg::*;

  logic [5:0]        msg_bits;
  logic              in_valid;
  logic              in_op;
  logic [MSG_W-1:0]  in_msg;
  logic [WORD_W-1:0] in_rcv;
  logic              out_valid;
  result_t           out_res;
  result_t           core_res;
  logic              advance;
  logic              s_take;

  // Length register
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_bits <= 6'd4;
    end else if (cfg_wr_en) begin
      msg_bits <= cfg_wr_data;
    end
  end

  // Pipeline flow: result slot frees when empty or taken
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      in_op  <= s_axis_tuser;
      in_msg <= s_axis_tdata[MSG_W-1:0];
      in_rcv <= s_axis_tdata[MSG_W+WORD_W-1:MSG_W];
    end
  end

  hec_core u_core (
    .operation (in_op),
    .message   (in_msg),
    .received  (in_rcv),
    .msg_bits  (msg_bits),
    .res       (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - RES_W)'(0), out_res};

endmodule

>>> rtl/hec_checker.sv
// Port-level assertions for the Hamming encoder/corrector, bound to the top.
`include "hamming_encode_correct_defines.svh"

module hec_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tready,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [hec_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import hec_pkg::*;

  logic       err_f;
  logic       bad_f;
  logic [5:0] syn_f;
  logic [2:0] pcnt_f;

  assign err_f    = m_axis_tdata[69];
  assign bad_f    = m_axis_tdata[70];
  assign syn_f    = m_axis_tdata[68:63];
  assign pcnt_f   = m_axis_tdata[73:71];

  // A stalled result holds
  `HEC_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // An empty result slot always takes a request
  `HEC_ASSERT_NOW(a_rate, clk, rst, !m_axis_tvalid, s_axis_tready, "request refused with empty output")

  // Flags agree with the syndrome
  `HEC_ASSERT_NOW(a_flags, clk, rst, m_axis_tvalid, (err_f == (syn_f != 6'd0)) && (!bad_f || err_f), "error flags inconsistent with syndrome")

  // Parity count in range, fill bits zero
  `HEC_ASSERT_NOW(a_range, clk, rst, m_axis_tvalid, (pcnt_f >= 3'd2) && (pcnt_f <= 3'd6) && (m_axis_tdata[79:74] == 6'd0), "parity count or fill out of range")

endmodule

bind hamming_encode_correct hec_checker u_hec_checker (.*);
